// ----- hdl/ffba_pkg.sv -----
`timescale 1ns / 1ps

package ffba_pkg;

  // table and address geometry
  localparam int MaxBlocks = 64;
  localparam int AddrBits  = 20;
  localparam int ArenaW    = 20;
  localparam int HdrW      = 7;
  localparam int CntW      = $clog2(MaxBlocks + 1);

  // the ring pass: one shift per table slot plus the merge queue lag
  localparam int PassLag = 4;
  localparam int PassLen = MaxBlocks + PassLag;
  localparam int TW      = $clog2(PassLen + 1);

  // merge queue
  localparam int QDepth = PassLag;
  localparam int QPtrW  = $clog2(QDepth);

  // configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgArena  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgHeader = 1'd1;

  // opcodes
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // status codes
  localparam logic [2:0] StatDone      = 3'd0;
  localparam logic [2:0] StatZeroSize  = 3'd1;
  localparam logic [2:0] StatArenaFull = 3'd2;
  localparam logic [2:0] StatTableFull = 3'd3;
  localparam logic [2:0] StatUnknown   = 3'd4;

  typedef struct packed {
    logic                opcode;
    logic [AddrBits-1:0] request_size;
    logic [AddrBits-1:0] address_in;
  } req_t;

  typedef struct packed {
    logic [AddrBits-1:0] address_out;
    logic [2:0]          status;
  } rsp_t;

  // one table entry: header offset, payload size, vacant flag
  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] size;
    logic                vacant;
  } entry_t;

  typedef struct packed {
    logic in_valid;
    logic flush;
    logic pop;
  } merge_ctrl_t;

endpackage

// ----- hdl/ffba_cell.sv -----
`timescale 1ns / 1ps

module ffba_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  ffba_pkg::entry_t d_i,
  output ffba_pkg::entry_t q_o
);

  ffba_pkg::entry_t entry_q;

  // take the neighbor's entry on every shift of the ring
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

// ----- hdl/ffba_merge.sv -----
`timescale 1ns / 1ps

module ffba_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ffba_pkg::merge_ctrl_t       ctrl_i,
  input  ffba_pkg::entry_t            in_entry_i,
  input  logic [ffba_pkg::HdrW-1:0]   hdr_i,
  output logic                        push_o,
  output logic                        q_empty_o,
  output ffba_pkg::entry_t            out_entry_o
);

  ffba_pkg::entry_t                 pend_q;
  logic                             pend_vld_q;
  ffba_pkg::entry_t                 mem_q [ffba_pkg::QDepth];
  logic [ffba_pkg::QPtrW-1:0]       wr_ptr_q;
  logic [ffba_pkg::QPtrW-1:0]       rd_ptr_q;
  logic [ffba_pkg::QPtrW:0]         fill_q;
  logic [ffba_pkg::QPtrW:0]         fill_d;
  logic                             can_merge;
  logic                             push;
  logic                             pop;
  ffba_pkg::entry_t                 merged;

  // a vacant run absorbs the next vacant entry and one header
  always_comb begin
    merged      = pend_q;
    merged.size = pend_q.size + ffba_pkg::AddrBits'(hdr_i) + in_entry_i.size;
  end

  assign can_merge = ctrl_i.in_valid && pend_vld_q && pend_q.vacant && in_entry_i.vacant;
  assign push      = pend_vld_q && ((ctrl_i.in_valid && !can_merge) || ctrl_i.flush);
  assign pop       = ctrl_i.pop && (fill_q != '0);

  always_comb begin
    fill_d = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fill_q     <= '0;
    end else begin
      if (ctrl_i.in_valid) begin
        pend_vld_q <= 1'b1;
      end else if (ctrl_i.flush) begin
        pend_vld_q <= 1'b0;
      end
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_d;
    end
  end

  // run register and finished-entry queue
  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_valid) begin
      pend_q <= can_merge ? merged : in_entry_i;
    end
    if (push) begin
      mem_q[wr_ptr_q] <= pend_q;
    end
  end

  assign push_o      = push;
  assign q_empty_o   = (fill_q == '0);
  assign out_entry_o = mem_q[rd_ptr_q];

  // queue never overflows within a pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (fill_q < ffba_pkg::QDepth))
    else $error("merge queue overflow");

  // an entry and the end of the stream never arrive together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.in_valid && ctrl_i.flush))
    else $error("entry and flush in the same cycle");

endmodule

// ----- hdl/first_fit_block_allocator.sv -----
`timescale 1ns / 1ps
// a zero-size allocate or a null free is answered in the cycle after its input transfer;
// otherwise the result comes at the end of one ring pass, in which the table ring streams
// every entry once past the search and merge logic
// one item in flight; the next transfer is taken the cycle after the result transfer
// reset: asynchronous active low, table empty, heap top 0, arena 65536, header 24

module first_fit_block_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ffba_pkg::req_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ffba_pkg::rsp_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [ffba_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ffba_pkg::ArenaW-1:0]     cfg_data_i
);

  localparam int NeedW = ffba_pkg::AddrBits + 2;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPass = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]                       state_q;
  logic [1:0]                       state_d;
  logic [ffba_pkg::ArenaW-1:0]      arena_q;
  logic [ffba_pkg::HdrW-1:0]        hdr_q;
  logic [ffba_pkg::CntW-1:0]        count_q;
  logic [ffba_pkg::AddrBits-1:0]    heap_top_q;
  logic [ffba_pkg::TW-1:0]          t_q;
  logic [ffba_pkg::CntW-1:0]        pcnt_q;
  logic                             found_q;
  logic                             appended_q;
  ffba_pkg::req_t                   req_q;
  logic [NeedW-1:0]                 need_q;
  logic                             full_q;
  logic [ffba_pkg::AddrBits-1:0]    addr_q;
  ffba_pkg::rsp_t                   rsp_q;

  logic                             accept;
  logic                             shift;
  logic [NeedW-1:0]                 need_d;
  ffba_pkg::entry_t                 cell_q [ffba_pkg::MaxBlocks];
  ffba_pkg::entry_t                 head;
  ffba_pkg::entry_t                 tail;
  ffba_pkg::entry_t                 in_entry;
  logic [ffba_pkg::AddrBits-1:0]    head_pay;
  logic                             is_alloc;
  logic                             real_entry;
  logic                             fit;
  logic                             hit;
  logic                             append_now;
  logic                             last_cycle;
  logic [ffba_pkg::TW-1:0]          t_count;
  ffba_pkg::merge_ctrl_t            mctrl;
  logic                             push;
  logic                             q_empty;
  ffba_pkg::rsp_t                   rsp_end;

  assign accept      = in_valid_i && (state_q == StIdle);
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = rsp_q;
  assign shift       = (state_q == StPass);
  assign last_cycle  = shift && (t_q == ffba_pkg::TW'(ffba_pkg::PassLen - 1));

  // end of the heap if the request were appended
  assign need_d = NeedW'(heap_top_q) + NeedW'(hdr_q) + NeedW'(in_data_i.request_size);

  // ring of table cells, the head feeds the search and the merge queue refills the tail
  for (genvar k = 0; k < ffba_pkg::MaxBlocks; k++) begin : g_cell
    if (k == ffba_pkg::MaxBlocks - 1) begin : g_tail
      ffba_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .d_i     (tail),
        .q_o     (cell_q[k])
      );
    end else begin : g_body
      ffba_cell u_cell (
        .clk_i   (clk_i),
        .shift_i (shift),
        .d_i     (cell_q[k+1]),
        .q_o     (cell_q[k])
      );
    end
  end

  // search and update at the head of the ring
  assign head       = cell_q[0];
  assign head_pay   = head.start + ffba_pkg::AddrBits'(hdr_q);
  assign is_alloc   = (req_q.opcode == ffba_pkg::OpAlloc);
  assign t_count    = ffba_pkg::TW'(count_q);
  assign real_entry = shift && (t_q < t_count);
  assign fit        = is_alloc && !found_q && head.vacant &&
                      (head.size >= req_q.request_size);
  assign hit        = !is_alloc && !found_q && (head_pay == req_q.address_in);
  assign append_now = shift && (t_q == t_count) && is_alloc && !found_q && !full_q &&
                      (count_q < ffba_pkg::CntW'(ffba_pkg::MaxBlocks));

  always_comb begin
    in_entry = head;
    if (real_entry && fit) begin
      in_entry.vacant = 1'b0;
    end
    if (real_entry && hit) begin
      in_entry.vacant = 1'b1;
    end
    if (append_now) begin
      in_entry.start  = heap_top_q;
      in_entry.size   = req_q.request_size;
      in_entry.vacant = 1'b0;
    end
  end

  // merge control: stream entries, close the last run, drain after the lag
  always_comb begin
    mctrl.in_valid = real_entry || append_now;
    mctrl.flush    = shift && ((appended_q && (t_q == t_count + 1'b1)) ||
                               (!appended_q && (t_q == t_count) && !append_now));
    mctrl.pop      = shift && (t_q >= ffba_pkg::TW'(ffba_pkg::PassLag));
  end

  ffba_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mctrl),
    .in_entry_i  (in_entry),
    .hdr_i       (hdr_q),
    .push_o      (push),
    .q_empty_o   (q_empty),
    .out_entry_o (tail)
  );

  // result at the end of the pass
  always_comb begin
    rsp_end.address_out = '0;
    rsp_end.status      = ffba_pkg::StatDone;
    if (is_alloc) begin
      if (found_q || appended_q) begin
        rsp_end.address_out = addr_q;
      end else if (full_q) begin
        rsp_end.status = ffba_pkg::StatArenaFull;
      end else begin
        rsp_end.status = ffba_pkg::StatTableFull;
      end
    end else if (!found_q) begin
      rsp_end.status = ffba_pkg::StatUnknown;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if ((in_data_i.opcode == ffba_pkg::OpAlloc) && (in_data_i.request_size == '0)) begin
            state_d = StOut;
          end else if ((in_data_i.opcode == ffba_pkg::OpFree) &&
                       (in_data_i.address_in == '0)) begin
            state_d = StOut;
          end else begin
            state_d = StPass;
          end
        end
      end
      StPass: begin
        if (last_cycle) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      arena_q    <= ffba_pkg::ArenaW'(65536);
      hdr_q      <= ffba_pkg::HdrW'(24);
      count_q    <= '0;
      heap_top_q <= '0;
      t_q        <= '0;
      pcnt_q     <= '0;
      found_q    <= 1'b0;
      appended_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ffba_pkg::CfgArena:  arena_q <= cfg_data_i;
          ffba_pkg::CfgHeader: hdr_q   <= cfg_data_i[ffba_pkg::HdrW-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        t_q        <= '0;
        pcnt_q     <= '0;
        found_q    <= 1'b0;
        appended_q <= 1'b0;
      end
      if (shift) begin
        t_q <= t_q + 1'b1;
        if (push) begin
          pcnt_q <= pcnt_q + 1'b1;
        end
        if (real_entry && (fit || hit)) begin
          found_q <= 1'b1;
        end
        if (append_now) begin
          appended_q <= 1'b1;
        end
      end
      if (last_cycle) begin
        count_q <= pcnt_q + ffba_pkg::CntW'(push);
        if (appended_q) begin
          heap_top_q <= need_q[ffba_pkg::AddrBits-1:0];
        end
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_data_i;
      need_q <= need_d;
      full_q <= (need_d > NeedW'(arena_q));
      rsp_q.address_out <= '0;
      rsp_q.status      <= (in_data_i.opcode == ffba_pkg::OpAlloc) ?
                           ffba_pkg::StatZeroSize : ffba_pkg::StatDone;
    end
    if (real_entry && fit) begin
      addr_q <= head_pay;
    end
    if (append_now) begin
      addr_q <= heap_top_q + ffba_pkg::AddrBits'(hdr_q);
    end
    if (last_cycle) begin
      rsp_q <= rsp_end;
    end
  end

  // table size stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ffba_pkg::CntW'(ffba_pkg::MaxBlocks))
    else $error("block count beyond table size");

  // every finished entry has been written back once the pass is over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_cycle |=> q_empty)
    else $error("merge queue not drained at end of pass");

  // the heap top never moves down
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |=> (heap_top_q >= $past(heap_top_q)))
    else $error("heap top moved down");

endmodule

// ----- verif/ffba_heap_checker.sv -----
`timescale 1ns / 1ps

module ffba_heap_checker
  import ffba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  req_t                in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rsp_t                out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ArenaW-1:0]   cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  // shadow copy of the block table and heap
  logic [AddrBits-1:0] blk_start  [MaxBlocks];
  logic [AddrBits-1:0] blk_size   [MaxBlocks];
  logic                blk_vacant [MaxBlocks];
  int                  blk_count;
  logic [AddrBits-1:0] heap_top;
  logic [ArenaW-1:0]   arena_lim;
  logic [HdrW-1:0]     hdr_len;

  // responses still owed by the block, oldest first
  rsp_t                owed_rsp_q[$];
  rsp_t                owed;

  // fold each run of adjacent vacant blocks into one, one header per fold
  function automatic void fold_vacant_runs();
    int i;
    int k;
    i = 0;
    while (i + 1 < blk_count) begin
      if (blk_vacant[i] && blk_vacant[i+1]) begin
        blk_size[i] = blk_size[i] + hdr_len + blk_size[i+1];
        for (k = i + 1; k + 1 < blk_count; k++) begin
          blk_start[k]  = blk_start[k+1];
          blk_size[k]   = blk_size[k+1];
          blk_vacant[k] = blk_vacant[k+1];
        end
        blk_count--;
      end else begin
        i++;
      end
    end
  endfunction

  // apply one request to the shadow heap and return the response it earns
  function automatic rsp_t heap_apply(req_t r);
    rsp_t                res;
    logic [AddrBits+1:0] need;
    logic [AddrBits-1:0] payload;
    res.address_out = '0;
    res.status      = StatDone;
    if (r.opcode == OpAlloc) begin
      if (r.request_size == '0) begin
        res.status = StatZeroSize;
        return res;
      end
      // first fit over vacant blocks, taken whole
      for (int i = 0; i < blk_count; i++) begin
        if (blk_vacant[i] && blk_size[i] >= r.request_size) begin
          blk_vacant[i]   = 1'b0;
          res.address_out = blk_start[i] + hdr_len;
          return res;
        end
      end
      // append at the heap top
      need = heap_top + hdr_len + r.request_size;
      if (need > arena_lim) begin
        res.status = StatArenaFull;
      end else if (blk_count >= MaxBlocks) begin
        res.status = StatTableFull;
      end else begin
        blk_start[blk_count]  = heap_top;
        blk_size[blk_count]   = r.request_size;
        blk_vacant[blk_count] = 1'b0;
        blk_count++;
        res.address_out = heap_top + hdr_len;
        heap_top        = need[AddrBits-1:0];
      end
    end else begin
      if (r.address_in == '0) return res;
      for (int i = 0; i < blk_count; i++) begin
        payload = blk_start[i] + hdr_len;
        if (payload == r.address_in) begin
          if (!blk_vacant[i]) begin
            blk_vacant[i] = 1'b1;
            fold_vacant_runs();
          end
          return res;
        end
      end
      res.status = StatUnknown;
    end
    return res;
  endfunction

  // watch transfers, predict on input, compare on output
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_count    = 0;
      heap_top     = '0;
      arena_lim    = ArenaW'(65536);
      hdr_len      = HdrW'(24);
      owed_rsp_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // result transfer
      if (out_valid_i && !out_stall_i) begin
        if (owed_rsp_q.size() == 0) begin
          $error("unexpected result: address_out %0d status %0d",
                 out_data_i.address_out, out_data_i.status);
          fail_count_o++;
        end else begin
          owed = owed_rsp_q.pop_front();
          if (out_data_i.address_out !== owed.address_out) begin
            $error("address_out mismatch: expected %0d, actual %0d",
                   owed.address_out, out_data_i.address_out);
            fail_count_o++;
          end
          if (out_data_i.status !== owed.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   owed.status, out_data_i.status);
            fail_count_o++;
          end
        end
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgArena:  arena_lim = cfg_data_i;
          CfgHeader: hdr_len   = cfg_data_i[HdrW-1:0];
          default: ;
        endcase
      end
      // request transfer
      if (in_valid_i && !in_stall_i) owed_rsp_q.push_back(heap_apply(in_data_i));
      pending_o = owed_rsp_q.size();
    end
  end

endmodule

// ----- verif/first_fit_block_allocator_test.sv -----
`timescale 1ns / 1ps

module first_fit_block_allocator_test;
  import ffba_pkg::*;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  req_t                in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  rsp_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = CfgArena;
  logic [ArenaW-1:0]   cfg_data  = '0;
  int                  fail_count;
  int                  pending;

  // traffic shaping knobs
  int                  idle_pct  = 0;
  int                  stall_pct = 0;
  int                  alloc_pct = 55;

  // header offsets of granted blocks, used to aim frees
  logic [HdrW-1:0]     cur_hdr   = HdrW'(24);
  logic [AddrBits-1:0] start_pool[$];

  first_fit_block_allocator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  ffba_heap_checker heap_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("first_fit_block_allocator verification failed");
    $finish;
  end

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // remember where granted blocks start
  always @(posedge clk) begin
    if (out_valid && !out_stall && out_data.address_out != '0) begin
      start_pool.push_back(out_data.address_out - cur_hdr);
      if (start_pool.size() > 200) void'(start_pool.pop_front());
    end
  end

  function automatic req_t alloc_req(logic [AddrBits-1:0] size);
    req_t r;
    r.opcode       = OpAlloc;
    r.request_size = size;
    r.address_in   = '0;
    return r;
  endfunction

  function automatic req_t free_req(logic [AddrBits-1:0] addr);
    req_t r;
    r.opcode       = OpFree;
    r.request_size = '0;
    r.address_in   = addr;
    return r;
  endfunction

  // random request, mostly frees of live blocks and small allocations
  function automatic req_t make_item();
    req_t r;
    int   pick;
    int   idx;
    r.opcode       = ($urandom_range(0, 99) < alloc_pct) ? OpAlloc : OpFree;
    r.request_size = AddrBits'($urandom());
    r.address_in   = AddrBits'($urandom());
    pick           = $urandom_range(0, 99);
    if (r.opcode == OpAlloc) begin
      if (pick < 5)       r.request_size = '0;
      else if (pick < 8)  r.request_size = '1;
      else if (pick < 10) r.request_size = AddrBits'($urandom());
      else if (pick < 28) r.request_size = AddrBits'($urandom_range(1, 4096));
      else                r.request_size = AddrBits'($urandom_range(1, 64));
    end else begin
      if (pick < 8) begin
        r.address_in = '0;
      end else if (pick < 16) begin
        // keep the random address
      end else if (start_pool.size() == 0) begin
        r.address_in = AddrBits'(cur_hdr);
      end else begin
        idx          = $urandom_range(0, start_pool.size() - 1);
        r.address_in = start_pool[idx] + cur_hdr;
        if (pick < 26) r.address_in = r.address_in + AddrBits'($urandom_range(1, 3));
        else if (pick < 90) start_pool.delete(idx);
      end
    end
    return r;
  endfunction

  // one request transfer, with random idle cycles in front
  task automatic drive(input req_t item, input bit gen);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    if (gen) item = make_item();
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every owed result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [ArenaW-1:0] data);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx == CfgHeader) cur_hdr = data[HdrW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // phase table: arena, header, sender idle, receiver stall, alloc share, count
  int ph_arena [7] = '{1048575, 1048575, 300000, 0, 1048575, 500000, 1048575};
  int ph_hdr   [7] = '{24, 1, 64, 8, 17, 40, 24};
  int ph_idle  [7] = '{0, 69, 0, 18, 0, 18, 0};
  int ph_stall [7] = '{0, 0, 69, 18, 0, 18, 69};
  int ph_alloc [7] = '{85, 55, 55, 45, 60, 50, 55};
  int ph_count [7] = '{250, 250, 300, 150, 250, 300, 300};

  initial begin
    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset arena and header
    drive(alloc_req('0), 1'b0);                 // zero size
    drive(free_req('0), 1'b0);                  // null free
    drive(free_req(AddrBits'(24)), 1'b0);       // free on an empty table
    drive(alloc_req(AddrBits'(100)), 1'b0);
    drive(alloc_req(AddrBits'(200)), 1'b0);
    drive(alloc_req(AddrBits'(50)), 1'b0);
    drive(free_req(AddrBits'(148)), 1'b0);
    drive(free_req(AddrBits'(148)), 1'b0);      // double free
    drive(free_req(AddrBits'(24)), 1'b0);       // merge with the next block
    drive(free_req(AddrBits'(148)), 1'b0);      // now inside a merged block
    drive(alloc_req(AddrBits'(324)), 1'b0);     // exact fit of the merged block
    drive(free_req(AddrBits'(372)), 1'b0);
    drive(alloc_req('1), 1'b0);                 // arena full at max size
    drive(alloc_req(AddrBits'(40)), 1'b0);      // reuse without split
    drive(free_req(AddrBits'(24)), 1'b0);
    drive(free_req(AddrBits'(372)), 1'b0);
    drive(alloc_req(AddrBits'(65090)), 1'b0);   // fills the arena exactly
    drive(alloc_req(AddrBits'(1)), 1'b0);       // one more byte once the arena is full
    drive(alloc_req(AddrBits'(398)), 1'b0);
    drive(free_req('1), 1'b0);                  // unknown at max address
    drive('{opcode: OpAlloc, request_size: AddrBits'(5), address_in: '1}, 1'b0);
    drive('{opcode: OpFree, request_size: '1, address_in: AddrBits'(446)}, 1'b0);

    // random phases, config changed only while idle and blocks are live
    for (int p = 0; p < 7; p++) begin
      cfg_write(CfgArena, ArenaW'(ph_arena[p]));
      cfg_write(CfgHeader, ArenaW'(ph_hdr[p]));
      idle_pct  = ph_idle[p];
      stall_pct = ph_stall[p];
      alloc_pct = ph_alloc[p];
      for (int n = 0; n < ph_count[p]; n++) begin
        if (p == 6 && n == ph_count[p] / 2) drain();
        drive('0, 1'b1);
      end
    end

    // wind down
    drain();
    stall_pct = 0;
    repeat (MaxBlocks + 16) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("first_fit_block_allocator verification clean");
    end else begin
      $display("first_fit_block_allocator verification failed");
    end
    $finish;
  end

endmodule
